FILE: hw/rtl/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// Line follower drive control package
// Shared types, register indexes and reset values of the drive controller.
// ----------------------------------------------------------------------------
package lfdc_pkg;

   localparam int COUNT_BITS_DEFAULT = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;
   localparam int SPEED_BITS     = 7;
   localparam int TICK_BITS      = 8;
   localparam int DRIVE_BITS     = 8;
   localparam int CALC_BITS      = 10;

   localparam int DRIVE_MAX = 100;

   localparam logic [SPEED_BITS-1:0] SLEW_LIMIT_RESET         = 7'd10;
   localparam logic [SPEED_BITS-1:0] BASE_SPEED_RESET         = 7'd30;
   localparam logic [SPEED_BITS-1:0] STRAIGHT_SPEED_RESET     = 7'd50;
   localparam logic [SPEED_BITS-1:0] SLIGHT_SPEED_RESET       = 7'd20;
   localparam logic [TICK_BITS-1:0]  STRAIGHT_TICKS_RESET     = 8'd10;
   localparam logic [TICK_BITS-1:0]  SLOW_TURN_TICKS_RESET    = 8'd5;
   localparam logic [TICK_BITS-1:0]  REVERSE_TURN_TICKS_RESET = 8'd10;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SLEW_LIMIT         = 3'd0,
      REG_BASE_SPEED         = 3'd1,
      REG_STRAIGHT_SPEED     = 3'd2,
      REG_SLIGHT_SPEED       = 3'd3,
      REG_STRAIGHT_TICKS     = 3'd4,
      REG_SLOW_TURN_TICKS    = 3'd5,
      REG_REVERSE_TURN_TICKS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] slew_limit;
      logic [SPEED_BITS-1:0] base_speed;
      logic [SPEED_BITS-1:0] straight_speed;
      logic [SPEED_BITS-1:0] slight_speed;
      logic [TICK_BITS-1:0]  straight_ticks;
      logic [TICK_BITS-1:0]  slow_turn_ticks;
      logic [TICK_BITS-1:0]  reverse_turn_ticks;
   } cfg_type;

   typedef struct packed {
      logic left;
      logic center;
      logic right;
   } sensor_type;

endpackage

FILE: hw/rtl/lfdc_if.sv
// ----------------------------------------------------------------------------
// Line follower drive control channels
// Valid/ready channels for sensor items, drive items and register writes.
// ----------------------------------------------------------------------------
interface lfdc_req_if;
   logic valid;
   logic ready;
   logic left_seen;
   logic center_seen;
   logic right_seen;

   modport source (output valid, output left_seen, output center_seen,
                   output right_seen, input ready);
   modport sink (input valid, input left_seen, input center_seen,
                 input right_seen, output ready);
endinterface

interface lfdc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [lfdc_pkg::DRIVE_BITS-1:0] left_drive;
   logic signed [lfdc_pkg::DRIVE_BITS-1:0] right_drive;

   modport source (output valid, output left_drive, output right_drive, input ready);
   modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

interface lfdc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lfdc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [lfdc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/line_follower_drive_control.sv
// ----------------------------------------------------------------------------
// Line follower drive control
// An accepted item is held in the sensor register; when it advances, the tick
// updates the wheel speed registers, which hold its drive item. One item per
// cycle while the receiver takes each drive item, set by the single tick update.
// Reset: settings return to their defaults, counters and speeds clear to zero.
// ----------------------------------------------------------------------------
module line_follower_drive_control #(
   parameter int COUNT_BITS = lfdc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   lfdc_req_if.sink          req_ch,
   lfdc_rsp_if.source        rsp_ch,
   lfdc_csr_if.sink          csr_ch
);

   lfdc_pkg::cfg_type    cfg;
   lfdc_pkg::sensor_type sensor_ff, sensor_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 count_clash;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign sensor_in    = '{left: req_ch.left_seen, center: req_ch.center_seen,
                           right: req_ch.right_seen};
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         sensor_ff <= sensor_in;
      end
   end

   lfdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid && csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   lfdc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance),
      .sensor      (sensor_ff),
      .cfg         (cfg),
      .left_drive  (rsp_ch.left_drive),
      .right_drive (rsp_ch.right_drive),
      .count_clash (count_clash)
   );

   assign rsp_ch.valid = out_valid_ff;

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.left_drive >= -8'sd100) && (rsp_ch.left_drive <= 8'sd100))
      else $error("Left drive left its range.");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.right_drive >= -8'sd100) && (rsp_ch.right_drive <= 8'sd100))
      else $error("Right drive left its range.");

   a_counts_exclusive: assert property (@(posedge clock) disable iff (reset)
      !count_clash)
      else $error("Turn and straight counters are both running.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && !in_valid_ff)
      else $error("Pipeline holds an item after reset.");

endmodule

FILE: hw/rtl/lfdc_csr.sv
// ----------------------------------------------------------------------------
// Line follower drive control registers
// Holds the speed and threshold settings written through the register port.
// ----------------------------------------------------------------------------
module lfdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [lfdc_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [lfdc_pkg::CSR_DATA_BITS-1:0]  wr_data,
   output lfdc_pkg::cfg_type                   cfg
);

   lfdc_pkg::cfg_type cfg_ff;
   lfdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (lfdc_pkg::csr_index_type'(wr_index))
            lfdc_pkg::REG_SLEW_LIMIT:
               cfg_in.slew_limit = wr_data[lfdc_pkg::SPEED_BITS-1:0];
            lfdc_pkg::REG_BASE_SPEED:
               cfg_in.base_speed = wr_data[lfdc_pkg::SPEED_BITS-1:0];
            lfdc_pkg::REG_STRAIGHT_SPEED:
               cfg_in.straight_speed = wr_data[lfdc_pkg::SPEED_BITS-1:0];
            lfdc_pkg::REG_SLIGHT_SPEED:
               cfg_in.slight_speed = wr_data[lfdc_pkg::SPEED_BITS-1:0];
            lfdc_pkg::REG_STRAIGHT_TICKS:
               cfg_in.straight_ticks = wr_data[lfdc_pkg::TICK_BITS-1:0];
            lfdc_pkg::REG_SLOW_TURN_TICKS:
               cfg_in.slow_turn_ticks = wr_data[lfdc_pkg::TICK_BITS-1:0];
            lfdc_pkg::REG_REVERSE_TURN_TICKS:
               cfg_in.reverse_turn_ticks = wr_data[lfdc_pkg::TICK_BITS-1:0];
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_limit         <= lfdc_pkg::SLEW_LIMIT_RESET;
         cfg_ff.base_speed         <= lfdc_pkg::BASE_SPEED_RESET;
         cfg_ff.straight_speed     <= lfdc_pkg::STRAIGHT_SPEED_RESET;
         cfg_ff.slight_speed       <= lfdc_pkg::SLIGHT_SPEED_RESET;
         cfg_ff.straight_ticks     <= lfdc_pkg::STRAIGHT_TICKS_RESET;
         cfg_ff.slow_turn_ticks    <= lfdc_pkg::SLOW_TURN_TICKS_RESET;
         cfg_ff.reverse_turn_ticks <= lfdc_pkg::REVERSE_TURN_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/lfdc_core.sv
// ----------------------------------------------------------------------------
// Line follower drive control tick logic
// Latches the sensors, runs the turn and straight counters, picks the wheel
// targets and slews the wheel speeds, one tick per cycle while tick is high.
// ----------------------------------------------------------------------------
module lfdc_core #(
   parameter int COUNT_BITS = lfdc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tick,
   input  lfdc_pkg::sensor_type                   sensor,
   input  lfdc_pkg::cfg_type                      cfg,
   output logic signed [lfdc_pkg::DRIVE_BITS-1:0] left_drive,
   output logic signed [lfdc_pkg::DRIVE_BITS-1:0] right_drive,
   output logic                                   count_clash
);

   localparam int CMP_BITS = (COUNT_BITS > lfdc_pkg::TICK_BITS) ? COUNT_BITS
                                                                 : lfdc_pkg::TICK_BITS;
   localparam int CB = lfdc_pkg::CALC_BITS;

   lfdc_pkg::sensor_type latched_ff, latched_in;
   logic [COUNT_BITS-1:0] turn_count_ff, turn_count_in;
   logic [COUNT_BITS-1:0] straight_count_ff, straight_count_in;
   logic signed [lfdc_pkg::DRIVE_BITS-1:0] left_speed_ff, left_speed_in;
   logic signed [lfdc_pkg::DRIVE_BITS-1:0] right_speed_ff, right_speed_in;

   logic signed [CB-1:0] base_s, half_s, turn_speed, left_goal, right_goal;
   logic                 turning;
   logic [COUNT_BITS-1:0] turn_count_up;

   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      r = (c == '1) ? c : c + 1'b1;
      return r;
   endfunction

   function automatic logic signed [lfdc_pkg::DRIVE_BITS-1:0] slew(
      input logic signed [lfdc_pkg::DRIVE_BITS-1:0] now,
      input logic signed [CB-1:0]                   target,
      input logic [lfdc_pkg::SPEED_BITS-1:0]        limit
   );
      logic signed [CB-1:0] lim;
      logic signed [CB-1:0] d;
      logic signed [CB-1:0] v;
      lim = $signed(CB'(limit));
      d   = target - CB'(now);
      if (d > lim) begin
         d = lim;
      end
      if (d < -lim) begin
         d = -lim;
      end
      v = CB'(now) + d;
      if (v > CB'(lfdc_pkg::DRIVE_MAX)) begin
         v = CB'(lfdc_pkg::DRIVE_MAX);
      end
      if (v < -CB'(lfdc_pkg::DRIVE_MAX)) begin
         v = -CB'(lfdc_pkg::DRIVE_MAX);
      end
      return v[lfdc_pkg::DRIVE_BITS-1:0];
   endfunction

   always_comb begin
      latched_in = latched_ff;
      if (sensor.left || sensor.center || sensor.right) begin
         latched_in = sensor;
      end

      base_s  = $signed(CB'(cfg.base_speed));
      half_s  = $signed(CB'(cfg.base_speed >> 1));
      turning = latched_in.left || latched_in.right;

      turn_count_up     = count_up(turn_count_ff);
      turn_count_in     = turning ? turn_count_up : turn_count_ff;
      straight_count_in = turning ? '0 : straight_count_ff;

      if (CMP_BITS'(turn_count_up) < CMP_BITS'(cfg.slow_turn_ticks)) begin
         turn_speed = half_s;
      end else if (CMP_BITS'(turn_count_up) < CMP_BITS'(cfg.reverse_turn_ticks)) begin
         turn_speed = '0;
      end else begin
         turn_speed = -half_s;
      end

      left_goal  = CB'(left_speed_ff);
      right_goal = CB'(right_speed_ff);
      priority if (latched_in.center && latched_in.left) begin
         right_goal = base_s;
         left_goal  = $signed(CB'(cfg.slight_speed));
      end else if (latched_in.center && latched_in.right) begin
         right_goal = $signed(CB'(cfg.slight_speed));
         left_goal  = base_s;
      end else if (latched_in.center) begin
         turn_count_in     = '0;
         straight_count_in = count_up(straight_count_ff);
         left_goal = (CMP_BITS'(straight_count_in) > CMP_BITS'(cfg.straight_ticks))
                     ? $signed(CB'(cfg.straight_speed)) : base_s;
         right_goal = left_goal;
      end else if (latched_in.left) begin
         right_goal = half_s;
         left_goal  = turn_speed;
      end else if (latched_in.right) begin
         right_goal = turn_speed;
         left_goal  = half_s;
      end else begin
         // Nothing has been seen yet, so both wheels hold their speed.
         left_goal  = CB'(left_speed_ff);
         right_goal = CB'(right_speed_ff);
      end

      left_speed_in  = slew(left_speed_ff, left_goal, cfg.slew_limit);
      right_speed_in = slew(right_speed_ff, right_goal, cfg.slew_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff        <= '0;
         turn_count_ff     <= '0;
         straight_count_ff <= '0;
         left_speed_ff     <= '0;
         right_speed_ff    <= '0;
      end else if (tick) begin
         latched_ff        <= latched_in;
         turn_count_ff     <= turn_count_in;
         straight_count_ff <= straight_count_in;
         left_speed_ff     <= left_speed_in;
         right_speed_ff    <= right_speed_in;
      end
   end

   assign left_drive  = left_speed_ff;
   assign right_drive = right_speed_ff;
   assign count_clash = (turn_count_ff != '0) && (straight_count_ff != '0);

endmodule

FILE: tb/line_follower_drive_control_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line follower drive control testbench
// Feeds sensor items through the request channel and checks every drive item
// against an in-bench model of the tick update. Register settings change
// between phases, and so do the idle and stall rates of the two channels.
// ----------------------------------------------------------------------------
module line_follower_drive_control_tb;

   localparam int COUNT_BITS = lfdc_pkg::COUNT_BITS_DEFAULT;
   localparam logic [lfdc_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
   localparam int HOLD_CYCLES = 200;

   localparam lfdc_pkg::sensor_type SEE_NONE = '{left: 1'b0, center: 1'b0, right: 1'b0};
   localparam lfdc_pkg::sensor_type SEE_LEFT = '{left: 1'b1, center: 1'b0, right: 1'b0};
   localparam lfdc_pkg::sensor_type SEE_CENTER = '{left: 1'b0, center: 1'b1, right: 1'b0};
   localparam lfdc_pkg::sensor_type SEE_RIGHT = '{left: 1'b0, center: 1'b0, right: 1'b1};
   localparam lfdc_pkg::sensor_type SEE_CENTER_LEFT =
      '{left: 1'b1, center: 1'b1, right: 1'b0};
   localparam lfdc_pkg::sensor_type SEE_CENTER_RIGHT =
      '{left: 1'b0, center: 1'b1, right: 1'b1};
   localparam lfdc_pkg::sensor_type SEE_ALL = '{left: 1'b1, center: 1'b1, right: 1'b1};
   localparam lfdc_pkg::sensor_type SEE_BOTH_SIDES =
      '{left: 1'b1, center: 1'b0, right: 1'b1};

   typedef struct packed {
      logic signed [lfdc_pkg::DRIVE_BITS-1:0] left;
      logic signed [lfdc_pkg::DRIVE_BITS-1:0] right;
   } drive_type;

   logic clock;
   logic reset;

   lfdc_req_if req_if ();
   lfdc_rsp_if rsp_if ();
   lfdc_csr_if csr_if ();

   line_follower_drive_control DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   lfdc_pkg::sensor_type sensor_backlog[$];
   drive_type expected_drives[$];
   lfdc_pkg::sensor_type next_sensor;
   drive_type wanted_drive;
   int fault_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic rsp_hold = 1'b0;
   bit hold_go = 1'b0;

   lfdc_pkg::cfg_type wheel_cfg;
   lfdc_pkg::sensor_type held_sensor;
   logic [COUNT_BITS-1:0] turn_ticks;
   logic [COUNT_BITS-1:0] straight_run;
   int left_now;
   int right_now;

   function automatic int slewed(input int now, input int target);
      int lim;
      int step;
      int v;
      lim = wheel_cfg.slew_limit;
      step = target - now;
      if (step > lim) step = lim;
      if (step < -lim) step = -lim;
      v = now + step;
      if (v > lfdc_pkg::DRIVE_MAX) v = lfdc_pkg::DRIVE_MAX;
      if (v < -lfdc_pkg::DRIVE_MAX) v = -lfdc_pkg::DRIVE_MAX;
      return v;
   endfunction

   function automatic drive_type predict_drive(input lfdc_pkg::sensor_type seen);
      int base;
      int half;
      int turn_speed;
      int left_goal;
      int right_goal;
      drive_type d;
      base = wheel_cfg.base_speed;
      half = wheel_cfg.base_speed / 2;
      turn_speed = 0;
      left_goal = left_now;
      right_goal = right_now;
      if (seen.left || seen.center || seen.right) held_sensor = seen;
      if (held_sensor.left || held_sensor.right) begin
         if (turn_ticks != '1) turn_ticks = turn_ticks + 1'b1;
         straight_run = '0;
         if (turn_ticks < wheel_cfg.slow_turn_ticks) turn_speed = half;
         else if (turn_ticks < wheel_cfg.reverse_turn_ticks) turn_speed = 0;
         else turn_speed = -half;
      end
      if (held_sensor.center && held_sensor.left) begin
         right_goal = base;
         left_goal = wheel_cfg.slight_speed;
      end else if (held_sensor.center && held_sensor.right) begin
         right_goal = wheel_cfg.slight_speed;
         left_goal = base;
      end else if (held_sensor.center) begin
         turn_ticks = '0;
         if (straight_run != '1) straight_run = straight_run + 1'b1;
         left_goal = (straight_run > wheel_cfg.straight_ticks) ?
                     int'(wheel_cfg.straight_speed) : base;
         right_goal = left_goal;
      end else if (held_sensor.left) begin
         right_goal = half;
         left_goal = turn_speed;
      end else if (held_sensor.right) begin
         right_goal = turn_speed;
         left_goal = half;
      end
      right_now = slewed(right_now, right_goal);
      left_now = slewed(left_now, left_goal);
      d.left = left_now[lfdc_pkg::DRIVE_BITS-1:0];
      d.right = right_now[lfdc_pkg::DRIVE_BITS-1:0];
      return d;
   endfunction

   function automatic void store_setting(input logic [lfdc_pkg::CSR_INDEX_BITS-1:0] idx,
                                         input logic [lfdc_pkg::CSR_DATA_BITS-1:0] value);
      case (idx)
         lfdc_pkg::REG_SLEW_LIMIT:
            wheel_cfg.slew_limit = value[lfdc_pkg::SPEED_BITS-1:0];
         lfdc_pkg::REG_BASE_SPEED:
            wheel_cfg.base_speed = value[lfdc_pkg::SPEED_BITS-1:0];
         lfdc_pkg::REG_STRAIGHT_SPEED:
            wheel_cfg.straight_speed = value[lfdc_pkg::SPEED_BITS-1:0];
         lfdc_pkg::REG_SLIGHT_SPEED:
            wheel_cfg.slight_speed = value[lfdc_pkg::SPEED_BITS-1:0];
         lfdc_pkg::REG_STRAIGHT_TICKS:
            wheel_cfg.straight_ticks = value[lfdc_pkg::TICK_BITS-1:0];
         lfdc_pkg::REG_SLOW_TURN_TICKS:
            wheel_cfg.slow_turn_ticks = value[lfdc_pkg::TICK_BITS-1:0];
         lfdc_pkg::REG_REVERSE_TURN_TICKS:
            wheel_cfg.reverse_turn_ticks = value[lfdc_pkg::TICK_BITS-1:0];
         default: ;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.left_seen = 1'b0;
      req_if.center_seen = 1'b0;
      req_if.right_seen = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      wheel_cfg.slew_limit = lfdc_pkg::SLEW_LIMIT_RESET;
      wheel_cfg.base_speed = lfdc_pkg::BASE_SPEED_RESET;
      wheel_cfg.straight_speed = lfdc_pkg::STRAIGHT_SPEED_RESET;
      wheel_cfg.slight_speed = lfdc_pkg::SLIGHT_SPEED_RESET;
      wheel_cfg.straight_ticks = lfdc_pkg::STRAIGHT_TICKS_RESET;
      wheel_cfg.slow_turn_ticks = lfdc_pkg::SLOW_TURN_TICKS_RESET;
      wheel_cfg.reverse_turn_ticks = lfdc_pkg::REVERSE_TURN_TICKS_RESET;
      held_sensor = SEE_NONE;
      turn_ticks = '0;
      straight_run = '0;
      left_now = 0;
      right_now = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (sensor_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_sensor = sensor_backlog.pop_front();
            req_if.valid <= 1'b1;
            req_if.left_seen <= next_sensor.left;
            req_if.center_seen <= next_sensor.center;
            req_if.right_seen <= next_sensor.right;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_drives.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("Unexpected drive item %0d/%0d at %0t",
                           rsp_if.left_drive, rsp_if.right_drive, $realtime);
            end else begin
               wanted_drive = expected_drives.pop_front();
               if (rsp_if.left_drive !== wanted_drive.left ||
                   rsp_if.right_drive !== wanted_drive.right) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("Drive mismatch at %0t: expected %0d/%0d, got %0d/%0d",
                              $realtime, wanted_drive.left, wanted_drive.right,
                              rsp_if.left_drive, rsp_if.right_drive);
               end
            end
         end
         if (req_if.valid && req_if.ready)
            expected_drives.push_back(predict_drive('{left: req_if.left_seen,
                                                      center: req_if.center_seen,
                                                      right: req_if.right_seen}));
      end
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic write_reg(input logic [lfdc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [lfdc_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      store_setting(idx, value);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (sensor_backlog.size() != 0 || req_if.valid || expected_drives.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_run(input lfdc_pkg::sensor_type seen, input int count);
      repeat (count) sensor_backlog.push_back(seen);
   endtask

   task automatic queue_random(input int count, input int max_run);
      lfdc_pkg::sensor_type course;
      int run_len;
      int queued;
      queued = 0;
      while (queued < count) begin
         course = lfdc_pkg::sensor_type'(3'($urandom_range(7)));
         run_len = ($urandom_range(99) < 80) ? int'($urandom_range(max_run, 1)) : 1;
         repeat (run_len) begin
            if ($urandom_range(99) < 10)
               sensor_backlog.push_back(lfdc_pkg::sensor_type'(3'($urandom_range(7))));
            else
               sensor_backlog.push_back(course);
            queued++;
         end
      end
   endtask

   task automatic program_settings(input int kind);
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] slew;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] base;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] cruise;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] slight;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] cruise_after;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] slow_below;
      logic [lfdc_pkg::CSR_DATA_BITS-1:0] reverse_from;
      slew = 8'($urandom_range(100, 1));
      base = 8'($urandom_range(100));
      cruise = 8'($urandom_range(100));
      slight = 8'($urandom_range(100));
      cruise_after = 8'($urandom_range(30));
      slow_below = 8'($urandom_range(15));
      reverse_from = 8'($urandom_range(25));
      case (kind)
         0: return;
         1: begin
            write_reg(REG_UNUSED, 8'($urandom_range(255)));
            slew = '1;
            base = '1;
            cruise = '1;
            slight = '1;
            cruise_after = '1;
            slow_below = '1;
            reverse_from = '1;
         end
         2: begin
            slew = '0;
            base = '0;
            cruise = '0;
            slight = '0;
            cruise_after = '0;
            slow_below = '0;
            reverse_from = '0;
         end
         3: begin
            slow_below = 8'($urandom_range(20, 6));
            reverse_from = 8'($urandom_range(5));
         end
         default: ;
      endcase
      write_reg(lfdc_pkg::REG_SLEW_LIMIT, slew);
      write_reg(lfdc_pkg::REG_BASE_SPEED, base);
      write_reg(lfdc_pkg::REG_STRAIGHT_SPEED, cruise);
      write_reg(lfdc_pkg::REG_SLIGHT_SPEED, slight);
      write_reg(lfdc_pkg::REG_STRAIGHT_TICKS, cruise_after);
      write_reg(lfdc_pkg::REG_SLOW_TURN_TICKS, slow_below);
      write_reg(lfdc_pkg::REG_REVERSE_TURN_TICKS, reverse_from);
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Nothing has been latched yet for the first items, so the speeds hold.
      push_run(SEE_NONE, 2);
      push_run(SEE_CENTER, 1);
      push_run(SEE_CENTER_LEFT, 1);
      push_run(SEE_CENTER_RIGHT, 1);
      push_run(SEE_ALL, 1);
      push_run(SEE_LEFT, 11);
      push_run(SEE_NONE, 1);
      push_run(SEE_RIGHT, 1);
      push_run(SEE_BOTH_SIDES, 1);
      push_run(SEE_CENTER, 1);

      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         program_settings(phase);
         case (phase % 4)
            0: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct <= 61;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct <= 0;
               receiver_stall_pct <= 61;
            end
            default: begin
               sender_idle_pct <= 14;
               receiver_stall_pct <= 14;
            end
         endcase
         if (phase == 1) begin
            // Long runs drive both counters into saturation.
            push_run(SEE_LEFT, 258);
            push_run(SEE_CENTER, 258);
            queue_random(20, 5);
         end else if (phase == 4) begin
            queue_random(60, 25);
            hold_go = 1'b1;
         end else begin
            queue_random(50, 25);
         end
      end

      wait_idle();
      if (fault_count == 0)
         $display("line_follower_drive_control_tb: clean");
      else
         $display("line_follower_drive_control_tb: errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("line_follower_drive_control_tb: errors");
      $finish;
   end

endmodule
